// ===== rtl/hcc_pkg.sv =====
`default_nettype none
package hcc_pkg;

    localparam int BASIS_FRAC   = 24;
    localparam int TENSION_FRAC = 12;
    localparam int TENSION_BITS = 16;
    localparam int OUT_BITS     = 18;
    localparam int ADDR_BITS    = 6;
    localparam int DATA_BITS    = 64;
    localparam logic [TENSION_BITS-1:0] TENSION_RESET = 16'd4096;

    typedef enum logic [2:0] {
        REG_IN_START  = 3'd0,
        REG_IN_END    = 3'd1,
        REG_OUT_START = 3'd2,
        REG_OUT_END   = 3'd3,
        REG_TENSION   = 3'd4
    } t_reg_idx;

endpackage
`default_nettype wire

// ===== rtl/hcc_tangent_solver.sv =====
`default_nettype none
module hcc_tangent_solver #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [3*COORD_BITS-1:0]               i_pt [4],
    input  logic [hcc_pkg::TENSION_BITS-1:0]      i_tension,
    output logic                                  o_busy,
    output logic signed [COORD_BITS+9:0]          o_t1 [3],
    output logic signed [COORD_BITS+9:0]          o_t2 [3]
);
    import hcc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int R  = C + 5;
    localparam int SW = C + 9;
    localparam int TW = C + 10;
    localparam int NW = 2 * C + 14;
    localparam int AW = 2 * C + 2;
    localparam int CW = $clog2(NW);
    localparam int PW = TENSION_BITS + R;

    localparam logic [1:0] VEC_CH = 2'd0;
    localparam logic [1:0] VEC_D1 = 2'd1;
    localparam logic [1:0] VEC_D2 = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SQ    = 6'b000010,
        S_ROOT  = 6'b000100,
        S_SCALE = 6'b001000,
        S_NUM   = 6'b010000,
        S_DIV   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]    r_vec, n_vec, r_k, n_k;
    logic [AW-1:0] r_acc, n_acc;
    logic [2*R-1:0] r_rad, n_rad;
    logic [R+1:0]  r_rem, n_rem;
    logic [R-1:0]  r_root, n_root;
    logic [SW-1:0] r_scale, n_scale;
    logic [NW-1:0] r_num, n_num;
    logic [R:0]    r_drem, n_drem;
    logic [CW-1:0] r_cnt, n_cnt;
    logic signed [TW-1:0] r_t1 [3];
    logic signed [TW-1:0] r_t2 [3];

    logic signed [D-1:0]   w_dif [3][3];
    logic signed [D-1:0]   w_sel;
    logic signed [2*D-1:0] w_sq;
    logic [D-1:0]    w_abs;
    logic [AW-1:0]   w_acc_nx;
    logic [R+1:0]    w_rsh, w_trial;
    logic [R-1:0]    w_root_nx;
    logic [R:0]      w_dsh;
    logic [NW-1:0]   w_num_nx;
    logic [PW-1:0]   w_sp;
    logic [D+SW-1:0] w_prod;
    logic signed [TW-1:0] w_tval;
    logic w_t_wr, w_zero_wr;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [C-1:0] a, p0, p1, e;
            a  = $signed(i_pt[0][k*C +: C]);
            p0 = $signed(i_pt[1][k*C +: C]);
            p1 = $signed(i_pt[2][k*C +: C]);
            e  = $signed(i_pt[3][k*C +: C]);
            w_dif[VEC_CH][k] = D'(p1) - D'(p0);
            w_dif[VEC_D1][k] = D'(p0) - D'(a);
            w_dif[VEC_D2][k] = D'(e) - D'(p1);
        end
    end

    assign w_sel    = w_dif[r_vec][r_k];
    assign w_sq     = w_sel * w_sel;
    assign w_abs    = w_sel[D-1] ? $unsigned(-w_sel) : $unsigned(w_sel);
    assign w_acc_nx = r_acc + $unsigned(w_sq);

    // restoring square root, two radicand bits a step
    assign w_rsh     = {r_rem[R-1:0], r_rad[2*R-1 -: 2]};
    assign w_trial   = {r_root, 2'b01};
    assign w_root_nx = {r_root[R-2:0], (w_rsh >= w_trial)};

    // restoring divide by the magnitude; quotient shifts into r_num
    assign w_dsh    = {r_drem[R-1:0], r_num[NW-1]};
    assign w_num_nx = {r_num[NW-2:0], (w_dsh >= {1'b0, r_root})};

    assign w_sp   = i_tension * r_root;
    assign w_prod = w_abs * r_scale;
    assign w_tval = w_sel[D-1] ? -$signed({1'b0, w_num_nx[SW-1:0]})
                               :  $signed({1'b0, w_num_nx[SW-1:0]});

    always_comb begin
        n_state   = r_state;
        n_vec     = r_vec;
        n_k       = r_k;
        n_acc     = r_acc;
        n_rad     = r_rad;
        n_rem     = r_rem;
        n_root    = r_root;
        n_scale   = r_scale;
        n_num     = r_num;
        n_drem    = r_drem;
        n_cnt     = r_cnt;
        w_t_wr    = 1'b0;
        w_zero_wr = 1'b0;
        case (r_state)
            S_IDLE: begin
            end
            S_SQ: begin
                n_acc = w_acc_nx;
                if (r_k == 2'd2) begin
                    n_rad   = {w_acc_nx, 8'b0};
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = CW'(R - 1);
                    n_k     = 2'd0;
                    n_state = S_ROOT;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_ROOT: begin
                n_rad  = {r_rad[2*R-3:0], 2'b00};
                n_rem  = (w_rsh >= w_trial) ? w_rsh - w_trial : w_rsh;
                n_root = w_root_nx;
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    if (r_vec == VEC_CH) begin
                        n_state = S_SCALE;
                    end else if (w_root_nx == '0) begin
                        // zero-length lane: tangent is zero
                        w_zero_wr = 1'b1;
                        if (r_vec == VEC_D1) begin
                            n_vec   = VEC_D2;
                            n_acc   = '0;
                            n_state = S_SQ;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_NUM;
                    end
                end
            end
            S_SCALE: begin
                n_scale = SW'((w_sp + (PW'(1) << (TENSION_FRAC - 1))) >> TENSION_FRAC);
                n_vec   = VEC_D1;
                n_k     = 2'd0;
                n_acc   = '0;
                n_state = S_SQ;
            end
            S_NUM: begin
                n_num   = {w_prod, 4'b0} + NW'(r_root >> 1);
                n_drem  = '0;
                n_cnt   = CW'(NW - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_num  = w_num_nx;
                n_drem = (w_dsh >= {1'b0, r_root}) ? w_dsh - {1'b0, r_root} : w_dsh;
                n_cnt  = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    w_t_wr = 1'b1;
                    if (r_k != 2'd2) begin
                        n_k     = r_k + 2'd1;
                        n_state = S_NUM;
                    end else if (r_vec == VEC_D1) begin
                        n_vec   = VEC_D2;
                        n_k     = 2'd0;
                        n_acc   = '0;
                        n_state = S_SQ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_start) begin
            n_state = S_SQ;
            n_vec   = VEC_CH;
            n_k     = 2'd0;
            n_acc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vec   <= VEC_CH;
            r_k     <= 2'd0;
            r_cnt   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_t1[k] <= '0;
                r_t2[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_vec   <= n_vec;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            if (w_t_wr) begin
                if (r_vec == VEC_D1) begin
                    r_t1[r_k] <= w_tval;
                end else begin
                    r_t2[r_k] <= w_tval;
                end
            end
            if (w_zero_wr) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_vec == VEC_D1) begin
                        r_t1[k] <= '0;
                    end else begin
                        r_t2[k] <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_rad   <= n_rad;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_scale <= n_scale;
        r_num   <= n_num;
        r_drem  <= n_drem;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_t1   = r_t1;
    assign o_t2   = r_t2;

endmodule
`default_nettype wire

// ===== rtl/hermite_corridor_curve_point_unit.sv =====
`default_nettype none
// Cubic Hermite point unit: joins the end of an incoming lane to the start of an
// outgoing lane and returns one saturated 3D point per curve parameter. Once busy
// is low, a parameter can be started every cycle; each point comes out on o_valid
// from a 7-stage pipeline (u^2, u^3, basis, products, sum, round). Every
// configuration write recomputes the two tangents with one shared bit-serial
// square root and divider; busy stays high from the write's access cycle until
// that solve is done.
// Results cannot be held off by the receiver.
module hermite_corridor_curve_point_unit #(
    parameter int COORD_BITS = 16,
    parameter int PARAM_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [PARAM_BITS-1:0]             i_position,
    output logic                              o_valid,
    output logic signed [hcc_pkg::OUT_BITS-1:0] o_point_x,
    output logic signed [hcc_pkg::OUT_BITS-1:0] o_point_y,
    output logic signed [hcc_pkg::OUT_BITS-1:0] o_point_z,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hcc_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [hcc_pkg::DATA_BITS-1:0]     pwdata,
    output logic [hcc_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready
);
    import hcc_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int TW   = C + 10;
    localparam int BF   = BASIS_FRAC;
    localparam int HW   = BF + 2;
    localparam int SUMW = HW + TW + 2;
    localparam int QW   = SUMW - (BF + 4);
    localparam logic [2*BF-1:0] HALF = (2*BF)'(1) << (BF - 1);
    localparam logic signed [QW-1:0] Q_LO = -(QW'(1) <<< (OUT_BITS - 1));
    localparam logic signed [QW-1:0] Q_HI = (QW'(1) <<< (OUT_BITS - 1)) - QW'(1);

    // ---------------- configuration ----------------
    logic [3*C-1:0]          r_pt [4];
    logic [TENSION_BITS-1:0] r_tension;
    logic w_wr, w_accept, w_solve_busy;
    t_reg_idx w_idx;

    assign pready   = 1'b1;
    assign w_wr     = psel & penable & pwrite;
    assign w_idx    = t_reg_idx'(paddr[5:3]);
    assign busy     = w_solve_busy | w_wr;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_pt[i] <= '0;
            end
            r_tension <= TENSION_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_IN_START:  r_pt[0]   <= pwdata[3*C-1:0];
                REG_IN_END:    r_pt[1]   <= pwdata[3*C-1:0];
                REG_OUT_START: r_pt[2]   <= pwdata[3*C-1:0];
                REG_OUT_END:   r_pt[3]   <= pwdata[3*C-1:0];
                REG_TENSION:   r_tension <= pwdata[TENSION_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_IN_START:  prdata = DATA_BITS'(r_pt[0]);
            REG_IN_END:    prdata = DATA_BITS'(r_pt[1]);
            REG_OUT_START: prdata = DATA_BITS'(r_pt[2]);
            REG_OUT_END:   prdata = DATA_BITS'(r_pt[3]);
            REG_TENSION:   prdata = DATA_BITS'(r_tension);
            default:       prdata = '0;
        endcase
    end

    logic signed [TW-1:0] w_t1 [3];
    logic signed [TW-1:0] w_t2 [3];

    hcc_tangent_solver #(
        .COORD_BITS(COORD_BITS)
    ) u_solver (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_wr),
        .i_pt     (r_pt),
        .i_tension(r_tension),
        .o_busy   (w_solve_busy),
        .o_t1     (w_t1),
        .o_t2     (w_t2)
    );

    // ---------------- point pipeline ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_valid;
    logic [BF-1:0] r1_u, r2_u, r2_u2, r3_u, r3_u2, r3_u3;
    logic signed [HW-1:0] r4_h1, r4_h2, r4_h3, r4_h4;
    logic signed [HW+C-1:0]  r5_a [3];
    logic signed [HW+C-1:0]  r5_b [3];
    logic signed [HW+TW-1:0] r5_c [3];
    logic signed [HW+TW-1:0] r5_d [3];
    logic signed [SUMW-1:0]  r6_sum [3];
    logic signed [OUT_BITS-1:0] r_pt_out [3];

    logic [2*BF-1:0] w_sq2, w_sq3;
    logic signed [HW+1:0] w_h1, w_h3, w_h4, w_u2s, w_u3s, w_us;

    assign w_sq2 = r1_u * r1_u + HALF;
    assign w_sq3 = r2_u2 * r2_u + HALF;
    assign w_u3s = $signed({4'b0000, r3_u3});
    assign w_u2s = $signed({4'b0000, r3_u2});
    assign w_us  = $signed({4'b0000, r3_u});
    assign w_h1  = (w_u3s <<< 1) - ((w_u2s <<< 1) + w_u2s) + ((HW+2)'(1) <<< BF);
    assign w_h3  = w_u3s - (w_u2s <<< 1) + w_us;
    assign w_h4  = w_u3s - w_u2s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= w_accept;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_v6    <= r_v5;
            r_valid <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_u  <= BF'(i_position) << (BF - PARAM_BITS);
        r2_u  <= r1_u;
        r2_u2 <= w_sq2[2*BF-1:BF];
        r3_u  <= r2_u;
        r3_u2 <= r2_u2;
        r3_u3 <= w_sq3[2*BF-1:BF];
        r4_h1 <= HW'(w_h1);
        r4_h2 <= HW'(((HW+2)'(1) <<< BF) - w_h1);
        r4_h3 <= HW'(w_h3);
        r4_h4 <= HW'(w_h4);
        for (int k = 0; k < 3; k++) begin
            logic signed [C-1:0] p0, p1;
            logic signed [SUMW-1:0] s, rs;
            p0 = $signed(r_pt[1][k*C +: C]);
            p1 = $signed(r_pt[2][k*C +: C]);
            r5_a[k] <= r4_h1 * p0;
            r5_b[k] <= r4_h2 * p1;
            r5_c[k] <= r4_h3 * w_t1[k];
            r5_d[k] <= r4_h4 * w_t2[k];
            s = (SUMW'(r5_a[k]) <<< 4) + (SUMW'(r5_b[k]) <<< 4)
              + SUMW'(r5_c[k]) + SUMW'(r5_d[k]);
            r6_sum[k] <= s;
            // round half up to whole input coordinate units, then clamp
            rs = r6_sum[k] + (SUMW'(1) <<< (BF + 3));
            if ($signed(rs[SUMW-1:BF+4]) < Q_LO) begin
                r_pt_out[k] <= Q_LO[OUT_BITS-1:0];
            end else if ($signed(rs[SUMW-1:BF+4]) > Q_HI) begin
                r_pt_out[k] <= Q_HI[OUT_BITS-1:0];
            end else begin
                r_pt_out[k] <= rs[BF+4+OUT_BITS-1:BF+4];
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_point_x = r_pt_out[0];
    assign o_point_y = r_pt_out[1];
    assign o_point_z = r_pt_out[2];

    // ---------------- checks ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##7 o_valid)
        else $error("point word not delivered at fixed latency");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> busy)
        else $error("tangent solve did not start after config write");

    a_no_start_solving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_solve_busy |=> !r_v1)
        else $error("word accepted while tangents were being solved");

endmodule
`default_nettype wire
